FILE: design/mke_pkg.sv
// Package for the masked k-mer extractor: sizes, lane result type and
// helper functions shared by the lane, merge and top-level modules.
// No dependencies.
package mke_pkg;

  localparam int unsigned MAX_KMER       = 32;
  localparam int unsigned BASES_PER_ITEM = 4;

  localparam int unsigned KEY_W   = 2 * MAX_KMER;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned KLEN_W  = 6;
  localparam int unsigned VALID_W = 3;
  localparam int unsigned PACK_W  = 2 * BASES_PER_ITEM;
  localparam int unsigned SEL_W   = (BASES_PER_ITEM > 1) ? $clog2(BASES_PER_ITEM) : 1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(15);
  localparam logic [POS_W-1:0]  POS_MAX    = '1;

  // Result found by one lane
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] start;
    logic             hit;
  } lane_res_t;

  // Clamp the configured length into 1..MAX_KMER
  function automatic logic [KLEN_W-1:0] eff_length(input logic [KLEN_W-1:0] k);
    logic [KLEN_W-1:0] r;
    r = k;
    if (r == '0) r = KLEN_W'(1);
    if (r > KLEN_W'(MAX_KMER)) r = KLEN_W'(MAX_KMER);
    return r;
  endfunction

  // Ones in the low 2k bits of the key, k in 1..MAX_KMER
  function automatic logic [KEY_W-1:0] key_mask(input logic [KLEN_W-1:0] k);
    logic [KEY_W-1:0] ones;
    ones = '1;
    return ones >> (8'(KEY_W) - {1'b0, k, 1'b0});
  endfunction

  // Clamp the valid-base count to the lane count
  function automatic logic [VALID_W-1:0] eff_valid(input logic [VALID_W-1:0] v);
    return (v > VALID_W'(BASES_PER_ITEM)) ? VALID_W'(BASES_PER_ITEM) : v;
  endfunction

endpackage

FILE: design/mke_lane.sv
// One extraction lane: shifts one base into the window, updates the clean
// run and reports a key when the window is complete and unmasked.
// Depends on mke_pkg.
module mke_lane (
  input  logic [mke_pkg::KEY_W-1:0]  win_i,
  input  logic [mke_pkg::KLEN_W-1:0] clean_i,
  input  logic [1:0]                 base_i,
  input  logic                       masked_i,
  input  logic [mke_pkg::POS_W-1:0]  pos_i,
  input  logic [mke_pkg::KLEN_W-1:0] k_i,
  input  logic [mke_pkg::KEY_W-1:0]  kmask_i,
  input  logic                       active_i,
  output logic [mke_pkg::KEY_W-1:0]  win_o,
  output logic [mke_pkg::KLEN_W-1:0] clean_o,
  output mke_pkg::lane_res_t         res_o
);
  import mke_pkg::*;

  logic [KEY_W-1:0]  win_shift;
  logic [KLEN_W-1:0] clean_next;

  // Shift the base in and update the unmasked run
  always_comb begin
    win_shift = {win_i[KEY_W-3:0], base_i};
    if (masked_i) begin
      clean_next = '0;
    end else if (clean_i < KLEN_W'(MAX_KMER)) begin
      clean_next = clean_i + KLEN_W'(1);
    end else begin
      clean_next = clean_i;
    end
  end

  // Pass state through when this lane has no base
  always_comb begin
    win_o       = active_i ? win_shift : win_i;
    clean_o     = active_i ? clean_next : clean_i;
    res_o.key   = win_shift & kmask_i;
    res_o.start = pos_i + POS_W'(1) - POS_W'(k_i);
    res_o.hit   = active_i && (clean_next >= k_i);
  end

endmodule

FILE: design/mke_merge.sv
// Merge stage: holds the lane results of one byte and hands the hits out
// one per transfer, in base order, through an output register.
// Depends on mke_pkg.
module mke_merge (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    accept_i,
  input  mke_pkg::lane_res_t [mke_pkg::BASES_PER_ITEM-1:0] res_i,
  output logic                                    ready_o,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [mke_pkg::KEY_W+mke_pkg::POS_W-1:0] m_axis_tdata_o,
  output logic                                    m_axis_tlast_o
);
  import mke_pkg::*;

  lane_res_t [BASES_PER_ITEM-1:0] res_q;
  logic [BASES_PER_ITEM-1:0]      pend_q, pend_d, pick, rest, new_hits;
  logic [SEL_W-1:0]               sel;
  logic                           move;
  logic                           out_valid_q, out_valid_d;
  logic [KEY_W-1:0]               key_q;
  logic [POS_W-1:0]               start_q;
  logic                           last_q;

  // Pick the lowest pending lane
  always_comb begin
    sel = '0;
    for (int i = BASES_PER_ITEM - 1; i >= 0; i--) begin
      if (pend_q[i]) sel = SEL_W'(i);
    end
    pick = pend_q & (~pend_q + BASES_PER_ITEM'(1));
    rest = pend_q & ~pick;
    for (int i = 0; i < BASES_PER_ITEM; i++) begin
      new_hits[i] = res_i[i].hit;
    end
  end

  // Advance a hit into the output register when it is free or draining
  always_comb begin
    move    = (pend_q != '0) && (!out_valid_q || m_axis_tready_i);
    ready_o = (pend_q == '0) || (move && (rest == '0));
    if (accept_i) begin
      pend_d = new_hits;
    end else if (move) begin
      pend_d = rest;
    end else begin
      pend_d = pend_q;
    end
    if (move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture lane results and the outgoing transfer
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_i;
    end
    if (move) begin
      key_q   <= res_q[sel].key;
      start_q <= res_q[sel].start;
      last_q  <= (rest == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {start_q, key_q};
  assign m_axis_tlast_o  = last_q;

`ifndef SYNTHESIS
  a_accept_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> ((pend_q == '0) || (move && ($countones(pend_q) == 1))))
    else $error("byte accepted while hits still pending");
  a_move_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q)
    else $error("moved hit did not reach the output register");
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && (rest == '0) && !accept_i) |=> (pend_q == '0))
    else $error("pending hits remain after last transfer of a byte");
  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pick))
    else $error("more than one lane picked");
`endif

endmodule

FILE: design/masked_kmer_extractor_core.sv
// Masked k-mer extractor: four lanes process the bases of one byte side by
// side; a merge stage serializes their keys. The merge stage registers the
// lane results at the byte transfer, and the first key then moves into its
// output register once that is free. Throughput: one byte per cycle when it
// yields at most one key and the output does not stall; otherwise the single output channel sets the rate.
// Reset (async, active low) clears window, position, run and output valid.
module masked_kmer_extractor_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [mke_pkg::KLEN_W-1:0]              cfg_wdata_i,   // kmer_length
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [7:0] packed_bases, [11:8] base_masks, [14:12] valid_bases, [15] zero
  input  logic [15:0]                             s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // [63:0] kmer_key, [95:64] start_position
  output logic [mke_pkg::KEY_W+mke_pkg::POS_W-1:0] m_axis_tdata_o,
  output logic                                    m_axis_tlast_o  // last_of_item
);
  import mke_pkg::*;

  logic [KLEN_W-1:0]  klen_q;
  logic [KEY_W-1:0]   win_q;
  logic [POS_W-1:0]   seen_q, seen_d;
  logic [KLEN_W-1:0]  clean_q;
  logic [KLEN_W-1:0]  k_eff;
  logic [KEY_W-1:0]   kmask;
  logic [VALID_W-1:0] v_eff;
  logic [PACK_W-1:0]  packed_bases;
  logic [BASES_PER_ITEM-1:0] base_masks;
  logic               accept, ready;
  logic [POS_W:0]     seen_sum;

  logic [KEY_W-1:0]   win_c   [BASES_PER_ITEM+1];
  logic [KLEN_W-1:0]  clean_c [BASES_PER_ITEM+1];
  lane_res_t [BASES_PER_ITEM-1:0] lane_res;

  // Unpack the input transfer
  assign packed_bases = s_axis_tdata_i[PACK_W-1:0];
  assign base_masks   = s_axis_tdata_i[PACK_W+BASES_PER_ITEM-1:PACK_W];
  assign v_eff        = eff_valid(s_axis_tdata_i[14:12]);
  assign k_eff        = eff_length(klen_q);
  assign kmask        = key_mask(k_eff);
  assign accept       = s_axis_tvalid_i && ready;
  assign s_axis_tready_o = ready;

  assign win_c[0]   = win_q;
  assign clean_c[0] = clean_q;

  // Lanes, one per base of the byte
  for (genvar g = 0; g < BASES_PER_ITEM; g++) begin : g_lane
    localparam int unsigned HI = 2 * (BASES_PER_ITEM - 1 - g) + 1;
    logic [POS_W:0]   pos_sum;
    logic [POS_W-1:0] pos;
    assign pos_sum = {1'b0, seen_q} + (POS_W+1)'(g);
    assign pos     = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

    mke_lane u_lane (
      .win_i    (win_c[g]),
      .clean_i  (clean_c[g]),
      .base_i   (packed_bases[HI -: 2]),
      .masked_i (base_masks[BASES_PER_ITEM-1-g]),
      .pos_i    (pos),
      .k_i      (k_eff),
      .kmask_i  (kmask),
      .active_i (VALID_W'(g) < v_eff),
      .win_o    (win_c[g+1]),
      .clean_o  (clean_c[g+1]),
      .res_o    (lane_res[g])
    );
  end

  // Advance the position by the bases taken, saturating
  assign seen_sum = {1'b0, seen_q} + (POS_W+1)'(v_eff);
  assign seen_d   = seen_sum[POS_W] ? POS_MAX : seen_sum[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= KLEN_RESET;
      win_q   <= '0;
      seen_q  <= '0;
      clean_q <= '0;
    end else begin
      if (cfg_we_i) begin
        klen_q <= cfg_wdata_i;
      end
      if (accept) begin
        win_q   <= win_c[BASES_PER_ITEM];
        seen_q  <= seen_d;
        clean_q <= clean_c[BASES_PER_ITEM];
      end
    end
  end

  mke_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .res_i           (lane_res),
    .ready_o         (ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_seen_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q >= $past(seen_q))
    else $error("base position went backwards");
  a_clean_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clean_q <= KLEN_W'(MAX_KMER))
    else $error("clean run beyond maximum length");
  a_empty_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (v_eff == '0)) |=> ($stable(win_q) && $stable(seen_q) && $stable(clean_q)))
    else $error("byte without bases changed the window state");
`endif

endmodule

FILE: tb/tb_masked_kmer_extractor_core.sv
// Self-checking testbench for masked_kmer_extractor_core: drives packed DNA bytes
// over the input stream and checks every window key against a built-in predictor.
// Depends on mke_pkg and the masked_kmer_extractor_core RTL only.
module tb_masked_kmer_extractor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mke_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned IDLE_PCT    = 23;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned SETTLE      = 8;

  // One input byte: fields from the highest bit down
  typedef struct packed {
    logic [VALID_W-1:0] nvalid;
    logic [3:0]         masks;
    logic [7:0]         bases;
  } dna_byte_t;

  // One window key as the output stream carries it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] start;
    logic             last;
  } kmer_hit_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                    cfg_we = 1'b0;
  logic [KLEN_W-1:0]       cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [15:0]             s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [KEY_W+POS_W-1:0]  m_tdata;
  logic                    m_tlast;

  // Stimulus and prediction state
  dna_byte_t   byte_queue[$];
  kmer_hit_t   kmer_expect[$];
  logic        in_took = 1'b0;
  logic        calm = 1'b0;
  logic [KEY_W-1:0]  window_q = '0;
  logic [POS_W-1:0]  base_index = '0;
  logic [KLEN_W-1:0] clean_len = '0;
  logic [KLEN_W-1:0] kmer_len = KLEN_RESET;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned keys_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned length_writes = 0;

  masked_kmer_extractor_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shift the valid bases of one byte through the window and queue the keys it completes
  function automatic void slide_byte(input dna_byte_t item);
    int unsigned       n;
    int unsigned       k;
    int unsigned       found;
    logic [KEY_W-1:0]  kmask;
    logic [1:0]        base;
    logic [POS_W-1:0]  pos;
    kmer_hit_t         hit;
    n = (item.nvalid > BASES_PER_ITEM) ? BASES_PER_ITEM : item.nvalid;
    k = kmer_len;
    if (k < 1) k = 1;
    if (k > MAX_KMER) k = MAX_KMER;
    kmask = (k >= MAX_KMER) ? '1 : ((KEY_W'(1) << (2 * k)) - KEY_W'(1));
    found = 0;
    for (int i = 0; i < n; i++) begin
      base = item.bases[7 - 2 * i -: 2];
      pos = base_index;
      window_q = {window_q[KEY_W-3:0], base};
      // a masked base breaks the clean run but still enters the window
      if (item.masks[3 - i]) clean_len = '0;
      else if (clean_len < MAX_KMER) clean_len = clean_len + 1'b1;
      if (clean_len >= k) begin
        hit.key = window_q & kmask;
        hit.start = pos + POS_W'(1) - POS_W'(k);
        hit.last = 1'b0;
        kmer_expect.insert(kmer_expect.size(), hit);
        found++;
      end
      if (base_index != POS_MAX) base_index = base_index + 1'b1;
    end
    // flag the final key of this byte
    if (found > 0) begin
      kmer_expect[kmer_expect.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", what);
  endfunction

  // Driver: present the next byte at the falling edge, idle at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (byte_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, byte_queue.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink: stall the output side at random
  always @(negedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: update the predictor on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    kmer_hit_t exp_hit;
    in_took = 1'b0;
    if (rst_ni) begin
      if (cfg_we) kmer_len = cfg_wdata;
      in_took = s_tvalid && s_tready;
      if (in_took) begin
        slide_byte(dna_byte_t'(s_tdata[14:0]));
        if (s_tdata[14:12] != 0) bytes_sent++;
      end
      if (m_tvalid && m_tready) begin
        keys_checked++;
        if (kmer_expect.size() == 0) begin
          note_mismatch($sformatf("unexpected key %h start %0d last %b",
                                  m_tdata[KEY_W-1:0], m_tdata[KEY_W +: POS_W], m_tlast));
        end else begin
          exp_hit = kmer_expect.pop_front();
          if (m_tdata[KEY_W-1:0] !== exp_hit.key || m_tdata[KEY_W +: POS_W] !== exp_hit.start
              || m_tlast !== exp_hit.last)
            note_mismatch($sformatf(
                "expected key %h start %0d last %b, got key %h start %0d last %b",
                exp_hit.key, exp_hit.start, exp_hit.last,
                m_tdata[KEY_W-1:0], m_tdata[KEY_W +: POS_W], m_tlast));
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d keys still expected", cycles, kmer_expect.size());
      $display("masked_kmer_extractor_core: mismatch");
      $finish;
    end
  end

  // Wait until every byte is sent and every key has come, then let the pipeline settle
  task automatic drain();
    while (byte_queue.size() != 0 || s_tvalid || kmer_expect.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_length(input logic [KLEN_W-1:0] k);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    length_writes++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic [3:0] m, input logic [2:0] v);
    dna_byte_t item;
    item.bases = b;
    item.masks = m;
    item.nvalid = v;
    byte_queue.insert(byte_queue.size(), item);
  endtask

  initial begin
    logic [KLEN_W-1:0] length_plan [RAND_PHASES];
    dna_byte_t         item;
    int unsigned       roll;

    length_plan[0] = KLEN_W'(1);
    length_plan[1] = KLEN_W'(32);
    length_plan[2] = KLEN_W'(0);
    length_plan[3] = KLEN_W'(63);
    length_plan[4] = KLEN_W'(5);
    length_plan[5] = KLEN_W'(24);
    length_plan[6] = KLEN_W'($urandom_range(2, 31));
    length_plan[7] = KLEN_W'(15);

    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset length of 15, base patterns, mask positions, odd valid counts
    push_byte(8'h1B, 4'h0, 3'd4);
    push_byte(8'hE4, 4'h0, 3'd4);
    push_byte(8'hFF, 4'h0, 3'd4);
    push_byte(8'h00, 4'h0, 3'd4);
    push_byte(8'hA5, 4'h0, 3'd4);
    push_byte(8'h5A, 4'hF, 3'd4);
    push_byte(8'h3C, 4'h8, 3'd4);
    push_byte(8'hC3, 4'h1, 3'd4);
    push_byte(8'h96, 4'h0, 3'd0);
    push_byte(8'h69, 4'h0, 3'd7);
    push_byte(8'h12, 4'h0, 3'd5);
    push_byte(8'h34, 4'h0, 3'd1);
    push_byte(8'h56, 4'h0, 3'd2);
    push_byte(8'h78, 4'h2, 3'd3);
    push_byte(8'h9A, 4'h4, 3'd6);
    drain();

    // Directed: full-width keys
    set_length(KLEN_W'(32));
    for (int i = 0; i < 9; i++) push_byte(8'($urandom), 4'h0, 3'd4);
    drain();

    // Random phases, one length each; the fourth runs with no idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_length(length_plan[ph]);
      calm = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.bases = 8'($urandom);
        roll = $urandom_range(0, 99);
        item.masks = (roll < 10) ? 4'($urandom) : 4'h0;
        roll = $urandom_range(0, 99);
        if (roll < 85) item.nvalid = 3'd4;
        else if (roll < 94) item.nvalid = 3'($urandom_range(1, 3));
        else item.nvalid = (roll < 96) ? 3'd0 : 3'($urandom_range(5, 7));
        byte_queue.insert(byte_queue.size(), item);
      end
      drain();
      calm = 1'b0;
    end

    $display("covered %0d bytes with bases, %0d keys checked, %0d length writes",
             bytes_sent, keys_checked, length_writes);
    $display("lengths 1, 0, 5, 15, 24, 32, 63 and one random value, with and without stalls");
    if (mismatches == 0 && kmer_expect.size() == 0) begin
      $display("masked_kmer_extractor_core: match");
    end else begin
      $display("%0d mismatches, %0d keys never seen", mismatches, kmer_expect.size());
      $display("masked_kmer_extractor_core: mismatch");
    end
    $finish;
  end

endmodule
